// ===== design/cepb_pkg.sv =====
// Package for the colour-effect pixel blend block: action, effect and operation codes,
// register indexes and the 5-bit saturating component helpers.
// No dependencies.
package cepb_pkg;

    localparam int COMP_W     = 5;
    localparam int NUM_COMP   = 3;
    localparam int COEF_DEPTH = 32;
    localparam int FADE_DEPTH = 64;
    localparam int APB_AW     = 5;

    localparam logic [15:0] NONE16    = 16'hFFFF;
    localparam int          BIT_SEMI  = 8;
    localparam int          BIT_BEHIND = 10;
    localparam int          BIT_FIRST = 15;

    typedef enum logic [2:0] {
        ACT_PIXEL       = 3'd0,
        ACT_LOAD_COEF_A = 3'd1,
        ACT_LOAD_COEF_B = 3'd2,
        ACT_LOAD_DARKEN = 3'd3,
        ACT_LOAD_BRIGHT = 3'd4,
        ACT_LOAD_PAL    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        FX_NONE     = 2'd0,
        FX_ALPHA    = 2'd1,
        FX_BRIGHTEN = 2'd2,
        FX_DARKEN   = 2'd3
    } t_effect;

    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_BLEND    = 2'd1,
        OP_BRIGHTEN = 2'd2,
        OP_DARKEN   = 2'd3
    } t_op;

    localparam logic [2:0] REG_EFFECT_MODE     = 3'd0;
    localparam logic [2:0] REG_SOURCE_BACKDROP = 3'd1;
    localparam logic [2:0] REG_TARGET_BACKDROP = 3'd2;
    localparam logic [2:0] REG_SOURCE_SPRITE   = 3'd3;
    localparam logic [2:0] REG_VIDEO_MODE      = 3'd4;
    localparam logic [2:0] REG_BACKDROP_COLOR  = 3'd5;

    function automatic logic [COMP_W-1:0] sat_add(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        logic [COMP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COMP_W] ? {COMP_W{1'b1}} : s[COMP_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] sat_sub(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        return (a >= b) ? (a - b) : {COMP_W{1'b0}};
    endfunction

endpackage

// ===== design/cepb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port and read enable.
// No dependencies.
module cepb_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/color_effect_pixel_blend_top.sv =====
// Channel  | handshake         | payload
// input    | i_valid / o_stall | i_action, i_table_index, i_table_value, i_source_pixel,
//          |                   | i_target_pixel, i_sprite_entry, i_last_pixel
// output   | o_valid / i_stall | o_out_color, o_out_last
// config   | APB write/read    | paddr, pwdata, prdata
// One word is accepted every cycle while o_stall is low; a pixel passes stages 0 to 3 and
// the output register, a depth set by the palette read followed by two dependent coefficient reads.
// Load words write the tables as they pass the stage that reads each copy, so they
// take effect in stream order and give no output word.
// Reset clears the valid bits and the configuration registers; the tables are undefined until loaded.
// A stall while an output word is held freezes the whole pipeline, RAM read ports included.
// Top level of the colour-effect pixel blend block. Depends on cepb_pkg and cepb_ram.
module color_effect_pixel_blend_top
    import cepb_pkg::*;
#(
    parameter int SPRITE_COLORS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_table_index,
    input  logic [14:0]       i_table_value,
    input  logic [15:0]       i_source_pixel,
    input  logic [15:0]       i_target_pixel,
    input  logic [15:0]       i_sprite_entry,
    input  logic              i_last_pixel,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_out_color,
    output logic              o_out_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PAL_AW = $clog2(SPRITE_COLORS);

    // Configuration registers
    logic [1:0]  r_effect_mode;
    logic        r_src_bd_en;
    logic        r_tgt_bd_en;
    logic        r_src_spr_en;
    logic [2:0]  r_video_mode;
    logic [14:0] r_backdrop;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode <= 2'd0;
            r_src_bd_en   <= 1'b0;
            r_tgt_bd_en   <= 1'b0;
            r_src_spr_en  <= 1'b0;
            r_video_mode  <= 3'd0;
            r_backdrop    <= 15'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_EFFECT_MODE:     r_effect_mode <= pwdata[1:0];
                REG_SOURCE_BACKDROP: r_src_bd_en   <= pwdata[0];
                REG_TARGET_BACKDROP: r_tgt_bd_en   <= pwdata[0];
                REG_SOURCE_SPRITE:   r_src_spr_en  <= pwdata[0];
                REG_VIDEO_MODE:      r_video_mode  <= pwdata[2:0];
                REG_BACKDROP_COLOR:  r_backdrop    <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_EFFECT_MODE:     prdata = {30'd0, r_effect_mode};
            REG_SOURCE_BACKDROP: prdata = {31'd0, r_src_bd_en};
            REG_TARGET_BACKDROP: prdata = {31'd0, r_tgt_bd_en};
            REG_SOURCE_SPRITE:   prdata = {31'd0, r_src_spr_en};
            REG_VIDEO_MODE:      prdata = {29'd0, r_video_mode};
            REG_BACKDROP_COLOR:  prdata = {17'd0, r_backdrop};
            default:             prdata = 32'd0;
        endcase
    end

    // Pipeline control
    logic r_out_valid;
    logic w_en;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // Palette index wraps modulo the palette size
    logic [12:0]       w_mod_v;
    logic [PAL_AW-1:0] w_pal_idx;

    always_comb begin
        w_mod_v = {5'd0, i_sprite_entry[7:0]};
        for (int k = 4; k >= 0; k--) begin
            if (w_mod_v >= (13'(SPRITE_COLORS) << k)) begin
                w_mod_v = w_mod_v - (13'(SPRITE_COLORS) << k);
            end
        end
    end

    assign w_pal_idx = w_mod_v[PAL_AW-1:0];

    // Stage 0: input register, palette access
    logic              r_s0_valid;
    logic [2:0]        r_s0_action;
    logic [7:0]        r_s0_idx;
    logic [14:0]       r_s0_val;
    logic [15:0]       r_s0_src;
    logic [15:0]       r_s0_tgt;
    logic [15:0]       r_s0_spr;
    logic              r_s0_last;
    logic [PAL_AW-1:0] r_s0_pal_idx;
    logic [14:0]       w_pal;
    logic              w_pal_wr;

    assign w_pal_wr = w_en && r_s0_valid && (r_s0_action == ACT_LOAD_PAL)
                      && ({1'b0, r_s0_idx} < 9'(SPRITE_COLORS));

    cepb_ram #(
        .WIDTH (15),
        .DEPTH (SPRITE_COLORS)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (w_pal_wr),
        .i_wr_addr (r_s0_idx[PAL_AW-1:0]),
        .i_wr_data (r_s0_val),
        .i_rd_en   (w_en),
        .i_rd_addr (r_s0_pal_idx),
        .o_rd_data (w_pal)
    );

    // Stage 1: effect decision, first coefficient reads
    logic        r_s1_valid;
    logic [2:0]  r_s1_action;
    logic [7:0]  r_s1_idx;
    logic [4:0]  r_s1_val;
    logic [15:0] r_s1_src;
    logic [15:0] r_s1_tgt;
    logic [15:0] r_s1_spr;
    logic        r_s1_last;

    logic [15:0] w_bk1;
    logic [15:0] w_bk2;
    logic [15:0] w_c1;
    logic [15:0] w_c2;
    logic [15:0] w_sp;
    logic [15:0] w_pal16;
    logic [15:0] w_col0;
    logic [15:0] w_key;
    logic        n_use_b1;
    logic [15:0] n_a1;
    logic [15:0] n_b1;
    logic [15:0] n_pv;
    t_op         n_op;

    assign w_pal16 = {1'b0, w_pal};

    always_comb begin
        w_bk1    = (r_src_bd_en || !r_tgt_bd_en) ? {1'b0, r_backdrop} : NONE16;
        w_bk2    = r_tgt_bd_en ? {1'b0, r_backdrop} : NONE16;
        w_c1     = r_s1_src;
        w_c2     = r_s1_tgt;
        w_sp     = r_s1_spr;
        w_key    = r_s1_src;
        w_col0   = r_s1_src;
        n_use_b1 = 1'b0;
        n_a1     = r_s1_src;
        n_b1     = r_s1_tgt;
        n_pv     = r_s1_src;
        n_op     = OP_NONE;
        unique case (r_effect_mode)
            FX_NONE: begin
                if (r_s1_spr == NONE16) begin
                    n_pv = r_s1_src;
                end else if (r_s1_spr[BIT_FIRST] || r_s1_spr[BIT_SEMI]) begin
                    n_pv = r_s1_src;
                    n_op = OP_BLEND;
                end else begin
                    n_pv = w_pal16;
                end
            end
            FX_ALPHA: begin
                if (!r_s1_src[15]) begin
                    if (r_s1_tgt[15]) begin
                        w_c2 = NONE16;
                    end else if (r_s1_spr[BIT_BEHIND]) begin
                        w_sp = NONE16;
                    end
                end else if (!r_s1_tgt[15]) begin
                    w_c1 = NONE16;
                    if (r_s1_spr[BIT_BEHIND]) begin
                        w_sp = NONE16;
                    end
                end else begin
                    w_c1 = w_bk1;
                    w_c2 = w_bk2;
                end
                if ((w_sp != NONE16) && !w_sp[BIT_SEMI]) begin
                    if (w_sp[BIT_FIRST]) begin
                        if (r_src_spr_en) begin
                            if (r_video_mode > 3'd2) begin
                                w_c2 = w_c1;
                            end
                            w_c1 = w_pal16;
                        end else begin
                            w_c2 = w_pal16;
                        end
                    end else begin
                        w_c1 = w_pal16;
                        w_c2 = NONE16;
                    end
                    w_sp = NONE16;
                end
                n_use_b1 = (w_c1 != NONE16) && (w_c2 != NONE16);
                n_a1     = w_c1;
                n_b1     = w_c2;
                n_pv     = (w_c1 == NONE16) ? w_c2 : w_c1;
                n_op     = (w_sp != NONE16) ? OP_BLEND : OP_NONE;
            end
            FX_BRIGHTEN, FX_DARKEN: begin
                w_key  = (r_s1_spr == NONE16) ? r_s1_src : r_s1_spr;
                w_col0 = (r_s1_spr == NONE16) ? r_s1_src : w_pal16;
                if (!w_key[15]) begin
                    n_pv = w_col0;
                    n_op = (r_effect_mode == FX_DARKEN) ? OP_DARKEN : OP_BRIGHTEN;
                end else if ((r_s1_spr != NONE16) && r_s1_spr[BIT_SEMI]) begin
                    n_pv = r_s1_src;
                    n_op = OP_BLEND;
                end else begin
                    n_pv = {1'b0, w_col0[14:0]};
                end
            end
        endcase
    end

    logic [COMP_W-1:0] w_ka [NUM_COMP];
    logic [COMP_W-1:0] w_kb [NUM_COMP];
    logic [COMP_W-1:0] w_kp [NUM_COMP];
    logic              w_s1_coef_a_wr;
    logic              w_s1_coef_b_wr;

    assign w_s1_coef_a_wr = w_en && r_s1_valid && (r_s1_action == ACT_LOAD_COEF_A)
                            && (r_s1_idx[7:5] == 3'd0);
    assign w_s1_coef_b_wr = w_en && r_s1_valid && (r_s1_action == ACT_LOAD_COEF_B)
                            && (r_s1_idx[7:5] == 3'd0);

    for (genvar g = 0; g < NUM_COMP; g++) begin : g_s1_lane
        cepb_ram #(.WIDTH(COMP_W), .DEPTH(COEF_DEPTH)) u_coef_a (
            .i_clk     (i_clk),
            .i_wr_en   (w_s1_coef_a_wr),
            .i_wr_addr (r_s1_idx[4:0]),
            .i_wr_data (r_s1_val),
            .i_rd_en   (w_en),
            .i_rd_addr (n_a1[COMP_W*g +: COMP_W]),
            .o_rd_data (w_ka[g])
        );
        cepb_ram #(.WIDTH(COMP_W), .DEPTH(COEF_DEPTH)) u_coef_b (
            .i_clk     (i_clk),
            .i_wr_en   (w_s1_coef_b_wr),
            .i_wr_addr (r_s1_idx[4:0]),
            .i_wr_data (r_s1_val),
            .i_rd_en   (w_en),
            .i_rd_addr (n_b1[COMP_W*g +: COMP_W]),
            .o_rd_data (w_kb[g])
        );
        cepb_ram #(.WIDTH(COMP_W), .DEPTH(COEF_DEPTH)) u_coef_p (
            .i_clk     (i_clk),
            .i_wr_en   (w_s1_coef_a_wr),
            .i_wr_addr (r_s1_idx[4:0]),
            .i_wr_data (r_s1_val),
            .i_rd_en   (w_en),
            .i_rd_addr (w_pal[COMP_W*g +: COMP_W]),
            .o_rd_data (w_kp[g])
        );
    end

    // Stage 2: first blend, second-level reads
    logic        r_s2_valid;
    logic [2:0]  r_s2_action;
    logic [7:0]  r_s2_idx;
    logic [4:0]  r_s2_val;
    logic        r_s2_last;
    logic        r_s2_use_b1;
    logic [15:0] r_s2_pv;
    t_op         r_s2_op;
    logic [15:0] w_x;
    logic        w_s2_coef_b_wr;
    logic        w_s2_fade_wr;

    always_comb begin
        w_x = r_s2_pv;
        if (r_s2_use_b1) begin
            w_x[15] = 1'b0;
            for (int g = 0; g < NUM_COMP; g++) begin
                w_x[COMP_W*g +: COMP_W] = sat_add(w_ka[g], w_kb[g]);
            end
        end
    end

    assign w_s2_coef_b_wr = w_en && r_s2_valid && (r_s2_action == ACT_LOAD_COEF_B)
                            && (r_s2_idx[7:5] == 3'd0);
    assign w_s2_fade_wr   = w_en && r_s2_valid && (r_s2_idx[7:5] == 3'd0)
                            && ((r_s2_action == ACT_LOAD_DARKEN)
                                || (r_s2_action == ACT_LOAD_BRIGHT));

    logic [COMP_W-1:0] w_kb2 [NUM_COMP];
    logic [COMP_W-1:0] w_kf  [NUM_COMP];

    for (genvar g = 0; g < NUM_COMP; g++) begin : g_s2_lane
        cepb_ram #(.WIDTH(COMP_W), .DEPTH(COEF_DEPTH)) u_coef_b2 (
            .i_clk     (i_clk),
            .i_wr_en   (w_s2_coef_b_wr),
            .i_wr_addr (r_s2_idx[4:0]),
            .i_wr_data (r_s2_val),
            .i_rd_en   (w_en),
            .i_rd_addr (w_x[COMP_W*g +: COMP_W]),
            .o_rd_data (w_kb2[g])
        );
        cepb_ram #(.WIDTH(COMP_W), .DEPTH(FADE_DEPTH)) u_fade (
            .i_clk     (i_clk),
            .i_wr_en   (w_s2_fade_wr),
            .i_wr_addr ({r_s2_action == ACT_LOAD_DARKEN, r_s2_idx[4:0]}),
            .i_wr_data (r_s2_val),
            .i_rd_en   (w_en),
            .i_rd_addr ({r_s2_op == OP_DARKEN, w_x[COMP_W*g +: COMP_W]}),
            .o_rd_data (w_kf[g])
        );
    end

    // Stage 3: second blend, fade or pass-through
    logic              r_s3_valid;
    logic              r_s3_pix;
    logic              r_s3_last;
    t_op               r_s3_op;
    logic [15:0]       r_s3_x;
    logic [COMP_W-1:0] r_s3_kp [NUM_COMP];
    logic [15:0]       w_col;

    always_comb begin
        w_col = r_s3_x;
        unique case (r_s3_op)
            OP_NONE: begin
                w_col = r_s3_x;
            end
            OP_BLEND: begin
                w_col[15] = 1'b0;
                for (int g = 0; g < NUM_COMP; g++) begin
                    w_col[COMP_W*g +: COMP_W] = sat_add(r_s3_kp[g], w_kb2[g]);
                end
            end
            OP_BRIGHTEN: begin
                w_col[15] = 1'b0;
                for (int g = 0; g < NUM_COMP; g++) begin
                    w_col[COMP_W*g +: COMP_W] = sat_add(r_s3_x[COMP_W*g +: COMP_W], w_kf[g]);
                end
            end
            OP_DARKEN: begin
                w_col[15] = 1'b0;
                for (int g = 0; g < NUM_COMP; g++) begin
                    w_col[COMP_W*g +: COMP_W] = sat_sub(r_s3_x[COMP_W*g +: COMP_W], w_kf[g]);
                end
            end
        endcase
    end

    // Output register
    logic [15:0] r_out_color;
    logic        r_out_last;

    assign o_valid     = r_out_valid;
    assign o_out_color = r_out_color;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid  <= i_valid;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid && r_s3_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_action  <= i_action;
            r_s0_idx     <= i_table_index;
            r_s0_val     <= i_table_value;
            r_s0_src     <= i_source_pixel;
            r_s0_tgt     <= i_target_pixel;
            r_s0_spr     <= i_sprite_entry;
            r_s0_last    <= i_last_pixel;
            r_s0_pal_idx <= w_pal_idx;

            r_s1_action <= r_s0_action;
            r_s1_idx    <= r_s0_idx;
            r_s1_val    <= r_s0_val[4:0];
            r_s1_src    <= r_s0_src;
            r_s1_tgt    <= r_s0_tgt;
            r_s1_spr    <= r_s0_spr;
            r_s1_last   <= r_s0_last;

            r_s2_action <= r_s1_action;
            r_s2_idx    <= r_s1_idx;
            r_s2_val    <= r_s1_val;
            r_s2_last   <= r_s1_last;
            r_s2_use_b1 <= n_use_b1;
            r_s2_pv     <= n_pv;
            r_s2_op     <= n_op;

            r_s3_pix  <= (r_s2_action == ACT_PIXEL);
            r_s3_last <= r_s2_last;
            r_s3_op   <= r_s2_op;
            r_s3_x    <= w_x;
            for (int g = 0; g < NUM_COMP; g++) begin
                r_s3_kp[g] <= w_kp[g];
            end

            r_out_color <= w_col;
            r_out_last  <= r_s3_last;
        end
    end

    a_word_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s3_valid && r_s3_pix))
        else $error("output word appeared without a pixel in the last stage");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid)
        else $error("input stalled while the output register is empty");

    a_effect_clears_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s3_valid && r_s3_pix && (r_s3_op != OP_NONE)) |=> !r_out_color[15])
        else $error("blended or faded colour carries bit 15");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s3_valid) && $stable(r_s3_x) && $stable(r_s2_valid))
        else $error("pipeline moved while frozen");

endmodule
